// ----- src/qfts_pkg.sv -----
// Package for the queue built from two stacks.
// Holds the operation and status codes shared by the top level and its checker.
// Depends on nothing.
`default_nettype none

package qfts_pkg;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } status_t;

endpackage

`default_nettype wire

// ----- src/queue_from_two_stacks_unit.sv -----
// Push, query and pop or peek of an empty queue give their result in the cycle after
// acceptance and busy stays low, so such items can be accepted every cycle. Pop or peek with
// a filled output stack passes through S_DELIVER and the next item can be accepted when its
// result appears; with an empty output stack the n elements of the input stack move over
// first, one a cycle, through S_XFER, S_FETCH and S_DELIVER. Results cannot be stalled. Reset
// clears both fill counts; the stack memories are not cleared. Depends on qfts_pkg and qfts_ram.
`default_nettype none

module queue_from_two_stacks_unit #(
    parameter int STACK_DEPTH = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         operation,
    input  wire logic signed [31:0] value,
    output logic                    done,
    output logic signed [31:0]      front_value,
    output logic                    is_empty,
    output logic [1:0]              status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_XFER,
        S_FETCH,
        S_DELIVER
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       in_count_reg, in_count_next;
    logic [CW-1:0]       out_count_reg, out_count_next;
    logic                pend_reg, pend_next;
    logic                is_pop_reg, is_pop_next;
    logic                done_reg, done_next;
    logic signed [31:0]  front_value_reg, front_value_next;
    logic                is_empty_reg, is_empty_next;
    qfts_pkg::status_t   status_reg, status_next;

    logic                accept;
    qfts_pkg::op_t       op;
    logic [CW-1:0]       in_top;
    logic [CW-1:0]       out_top;

    logic                in_wr_en;
    logic [DATA_WIDTH-1:0] in_rd_data;
    logic                out_wr_en;
    logic [DATA_WIDTH-1:0] out_rd_data;

    assign accept  = start && (state_reg == S_IDLE);
    assign op      = qfts_pkg::op_t'(operation);
    assign in_top  = in_count_reg - CW'(1);
    assign out_top = out_count_reg - CW'(1);

    qfts_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_in_ram (
        .clk     (clk),
        .wr_en   (in_wr_en),
        .wr_addr (in_count_reg[AW-1:0]),
        .wr_data (DATA_WIDTH'($unsigned(value))),
        .rd_addr (in_top[AW-1:0]),
        .rd_data (in_rd_data)
    );

    qfts_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_out_ram (
        .clk     (clk),
        .wr_en   (out_wr_en),
        .wr_addr (out_count_reg[AW-1:0]),
        .wr_data (in_rd_data),
        .rd_addr (out_top[AW-1:0]),
        .rd_data (out_rd_data)
    );

    always_comb
    begin
        state_next       = state_reg;
        in_count_next    = in_count_reg;
        out_count_next   = out_count_reg;
        pend_next        = pend_reg;
        is_pop_next      = is_pop_reg;
        done_next        = 1'b0;
        front_value_next = front_value_reg;
        status_next      = status_reg;
        in_wr_en         = 1'b0;
        out_wr_en        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    is_pop_next = (op == qfts_pkg::OP_POP);
                    case (op)
                        qfts_pkg::OP_PUSH:
                        begin
                            done_next        = 1'b1;
                            front_value_next = '0;
                            if (in_count_reg == CW'(STACK_DEPTH))
                            begin
                                status_next = qfts_pkg::ST_OVER;
                            end
                            else
                            begin
                                status_next   = qfts_pkg::ST_OK;
                                in_wr_en      = 1'b1;
                                in_count_next = in_count_reg + CW'(1);
                            end
                        end
                        qfts_pkg::OP_POP, qfts_pkg::OP_PEEK:
                        begin
                            if (out_count_reg != '0)
                            begin
                                state_next = S_DELIVER;
                            end
                            else if (in_count_reg != '0)
                            begin
                                state_next = S_XFER;
                                pend_next  = 1'b0;
                            end
                            else
                            begin
                                done_next        = 1'b1;
                                front_value_next = '0;
                                status_next      = qfts_pkg::ST_UNDER;
                            end
                        end
                        default:
                        begin
                            done_next        = 1'b1;
                            front_value_next = '0;
                            status_next      = qfts_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_XFER:
            begin
                if (pend_reg)
                begin
                    out_wr_en      = 1'b1;
                    out_count_next = out_count_reg + CW'(1);
                end
                if (in_count_reg != '0)
                begin
                    in_count_next = in_top;
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_DELIVER;
            end
            S_DELIVER:
            begin
                state_next       = S_IDLE;
                done_next        = 1'b1;
                front_value_next = 32'($signed(out_rd_data));
                status_next      = qfts_pkg::ST_OK;
                if (is_pop_reg)
                begin
                    out_count_next = out_top;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        is_empty_next = (in_count_next == '0) && (out_count_next == '0);
        if (!done_next)
        begin
            is_empty_next = is_empty_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_count_reg  <= '0;
            out_count_reg <= '0;
            pend_reg      <= 1'b0;
            is_pop_reg    <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_count_reg  <= in_count_next;
            out_count_reg <= out_count_next;
            pend_reg      <= pend_next;
            is_pop_reg    <= is_pop_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_value_reg <= front_value_next;
        is_empty_reg    <= is_empty_next;
        status_reg      <= status_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign front_value = front_value_reg;
    assign is_empty    = is_empty_reg;
    assign status      = status_reg;

endmodule

`default_nettype wire

// ----- src/qfts_ram.sv -----
// Single-port-write, single-port-read memory that backs one stack.
// The read data is registered. Depends on nothing.
`default_nettype none

module qfts_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- src/qfts_checker.sv -----
// Port-level checks for the queue built from two stacks, bound to the top level.
// Depends on qfts_pkg and queue_from_two_stacks_unit.
`default_nettype none

module qfts_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic [1:0]         operation,
    input wire logic               done,
    input wire logic signed [31:0] front_value,
    input wire logic               is_empty,
    input wire logic [1:0]         status
);

    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (($past(start) && !$past(busy)) || $past(busy)))
        else $error("Result strobe without an accepted item.");

    a_push_query_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == qfts_pkg::OP_PUSH || operation == qfts_pkg::OP_QUERY))
        |=> (done && !busy))
        else $error("Push or query did not finish in one cycle.");

    a_underflow_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == qfts_pkg::ST_UNDER) |-> (front_value == 32'sd0 && is_empty))
        else $error("Underflow result must be zero on an empty queue.");

    a_overflow_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == qfts_pkg::ST_OVER) |-> (!is_empty && front_value == 32'sd0))
        else $error("Overflow reported while the queue is empty.");

endmodule

bind queue_from_two_stacks_unit qfts_checker u_qfts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .done        (done),
    .front_value (front_value),
    .is_empty    (is_empty),
    .status      (status)
);

`default_nettype wire
